>>> hw/rtl/jdcd_pkg.sv
// ----------------------------------------------------------------------------
// Julian day to calendar date: shared package
// Constants, reciprocals for the constant dividers, the stage control type
// and the month start table.
// ----------------------------------------------------------------------------
package jdcd_pkg;

   localparam logic [31:0] GREG_START = 32'd2299161;
   localparam logic [31:0] GREG_YEAR0 = 32'd1721060;

   localparam int JUL_CYCLE   = 1461;
   localparam int GREG_CYCLE  = 146097;
   localparam int CENT_FIRST  = 36525;
   localparam int CENT_DAYS   = 36524;
   localparam int QUAD_COMMON = 1460;
   localparam int YEAR_DAYS   = 365;
   localparam int BC_FIRST    = 4713;
   localparam int AD_OFFSET   = 4712;

   localparam int JUL_SHIFT  = 32;
   localparam int GREG_SHIFT = 49;
   localparam int QUAD_SHIFT = 27;

   localparam logic [31:0] JUL_RECIP  = 32'((64'd1 << JUL_SHIFT) / 64'd1461);
   localparam logic [31:0] GREG_RECIP = 32'((64'd1 << GREG_SHIFT) / 64'd146097);
   localparam logic [16:0] QUAD_RECIP = 17'((64'd1 << QUAD_SHIFT) / 64'd1461);

   localparam int CYC_W  = 15;
   localparam int REM_W  = 18;
   localparam int GRP_W  = 16;
   localparam int BASE_W = 9;
   localparam int Q3_W   = 5;
   localparam int VAL_W  = 11;
   localparam int DOY_W  = 9;
   localparam int YEAR_W = 24;

   typedef struct packed {
      logic valid;
      logic greg;
   } jdcd_ctl_type;

   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m, input logic leap);
      logic [DOY_W-1:0] s;
      unique case (m)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd59;
         4'd3:    s = 9'd90;
         4'd4:    s = 9'd120;
         4'd5:    s = 9'd151;
         4'd6:    s = 9'd181;
         4'd7:    s = 9'd212;
         4'd8:    s = 9'd243;
         4'd9:    s = 9'd273;
         4'd10:   s = 9'd304;
         4'd11:   s = 9'd334;
         default: s = 9'd365;
      endcase
      if (leap && m >= 4'd2) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

endpackage

>>> hw/rtl/jdcd_divmod.sv
// ----------------------------------------------------------------------------
// Julian day to calendar date: cycle divider
// Three-stage division of the day count by the 4-year or 400-year cycle
// length, using a reciprocal multiply, a back multiply and one correction.
// ----------------------------------------------------------------------------
module jdcd_divmod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  jdcd_pkg::jdcd_ctl_type        in_ctl,
   input  logic [31:0]                   in_value,
   output jdcd_pkg::jdcd_ctl_type        out_ctl,
   output logic [jdcd_pkg::CYC_W-1:0]    out_cycles,
   output logic [jdcd_pkg::REM_W-1:0]    out_rem
);
   import jdcd_pkg::*;

   logic [31:0]      recip_a;
   logic [63:0]      prod_a;
   logic [CYC_W-1:0] qest_a_in;

   jdcd_ctl_type     ctl_a_ff;
   logic [31:0]      val_a_ff;
   logic [CYC_W-1:0] qest_a_ff;

   logic [32:0]      div_a;
   logic [32:0]      prod_b_in;

   jdcd_ctl_type     ctl_b_ff;
   logic [31:0]      val_b_ff;
   logic [CYC_W-1:0] qest_b_ff;
   logic [32:0]      prod_b_ff;

   logic [32:0]      div_b;
   logic [32:0]      diff_b;
   logic [CYC_W-1:0] cyc_c_in;
   logic [REM_W-1:0] rem_c_in;

   jdcd_ctl_type     ctl_c_ff;
   logic [CYC_W-1:0] cyc_c_ff;
   logic [REM_W-1:0] rem_c_ff;

   assign recip_a = in_ctl.greg ? GREG_RECIP : JUL_RECIP;
   assign prod_a  = 64'(in_value) * 64'(recip_a);
   assign qest_a_in = in_ctl.greg ? CYC_W'(prod_a >> GREG_SHIFT) : CYC_W'(prod_a >> JUL_SHIFT);

   assign div_a     = ctl_a_ff.greg ? 33'(GREG_CYCLE) : 33'(JUL_CYCLE);
   assign prod_b_in = 33'(qest_a_ff) * div_a;

   assign div_b  = ctl_b_ff.greg ? 33'(GREG_CYCLE) : 33'(JUL_CYCLE);
   assign diff_b = {1'b0, val_b_ff} - prod_b_ff;

   always_comb begin
      if (diff_b >= div_b) begin
         cyc_c_in = qest_b_ff + CYC_W'(1);
         rem_c_in = REM_W'(diff_b - div_b);
      end else begin
         cyc_c_in = qest_b_ff;
         rem_c_in = REM_W'(diff_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else if (enable) begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         val_a_ff  <= in_value;
         qest_a_ff <= qest_a_in;
         val_b_ff  <= val_a_ff;
         qest_b_ff <= qest_a_ff;
         prod_b_ff <= prod_b_in;
         cyc_c_ff  <= cyc_c_in;
         rem_c_ff  <= rem_c_in;
      end
   end

   assign out_ctl    = ctl_c_ff;
   assign out_cycles = cyc_c_ff;
   assign out_rem    = rem_c_ff;

endmodule

>>> hw/rtl/julian_day_to_calendar_date_unit.sv
// ----------------------------------------------------------------------------
// Julian day to calendar date unit
// Converts a day count since 1 January 4713 BC into day, month, year and era,
// Julian before 15 October 1582 and Gregorian from then on.
//
//   channel | ports                                   | direction
//   req     | req_valid, req_ready, req_day_number    | in
//   rsp     | rsp_valid, rsp_ready, rsp_day_of_month, | out
//           | rsp_month_number, rsp_year_number,      |
//           | rsp_before_christ                       |
//
// One transaction enters per cycle while no result waits for rsp_ready; each
// result reaches the rsp ports through the nine register stages of the
// pipeline, the first of which loads at the accepting edge; three
// of them are in the cycle divider and two in the 4-year group divider.
// Synchronous reset clears the control bits (valid and calendar) of all stages only.
// While a result waits for rsp_ready, the whole pipeline holds and req_ready
// is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_day_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_number,
   output logic [23:0] rsp_year_number,
   output logic        rsp_before_christ
);
   import jdcd_pkg::*;

   logic advance;

   jdcd_ctl_type ctl_1_in;
   jdcd_ctl_type ctl_1_ff;
   logic [31:0]  x_1_in;
   logic [31:0]  x_1_ff;

   jdcd_ctl_type     ctl_4;
   logic [CYC_W-1:0] cyc_4;
   logic [REM_W-1:0] rem_4;

   logic [16:0]       r2_4;
   logic [1:0]        k_4;
   logic [GRP_W-1:0]  s_4;
   logic [GRP_W-1:0]  g_5_in;
   logic [BASE_W-1:0] base_5_in;
   logic              lf_5_in;
   logic [YEAR_W-1:0] cy_5_in;

   jdcd_ctl_type      ctl_5_ff;
   logic [GRP_W-1:0]  g_5_ff;
   logic [BASE_W-1:0] base_5_ff;
   logic              lf_5_ff;
   logic [YEAR_W-1:0] cy_5_ff;

   logic [32:0]       gprod_5;
   logic [Q3_W-1:0]   q3_6_in;

   jdcd_ctl_type      ctl_6_ff;
   logic [GRP_W-1:0]  g_6_ff;
   logic [BASE_W-1:0] base_6_ff;
   logic              lf_6_ff;
   logic [YEAR_W-1:0] cy_6_ff;
   logic [Q3_W-1:0]   q3_6_ff;

   logic [GRP_W-1:0]  vraw_6;
   logic [VAL_W-1:0]  v_7_in;
   logic [Q3_W-1:0]   q3_7_in;

   jdcd_ctl_type      ctl_7_ff;
   logic [VAL_W-1:0]  v_7_ff;
   logic [Q3_W-1:0]   q3_7_ff;
   logic [BASE_W-1:0] base_7_ff;
   logic              lf_7_ff;
   logic [YEAR_W-1:0] cy_7_ff;

   logic [VAL_W-1:0]  lfx_7;
   logic [1:0]        yi_7;
   logic [DOY_W-1:0]  doy_8_in;
   logic              leap_8_in;
   logic [YEAR_W-1:0] ysum_8_in;

   jdcd_ctl_type      ctl_8_ff;
   logic [DOY_W-1:0]  doy_8_ff;
   logic              leap_8_ff;
   logic [YEAR_W-1:0] ysum_8_ff;

   logic [3:0]        mon_8;
   logic [4:0]        day_9_in;
   logic [YEAR_W-1:0] year_9_in;
   logic              bc_9_in;

   logic              rsp_valid_ff;
   logic [4:0]        day_9_ff;
   logic [3:0]        mon_9_ff;
   logic [YEAR_W-1:0] year_9_ff;
   logic              bc_9_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1: pick the calendar and rebase Gregorian day counts.
   assign ctl_1_in.valid = req_valid;
   assign ctl_1_in.greg  = (req_day_number >= GREG_START);
   assign x_1_in = ctl_1_in.greg ? req_day_number - GREG_YEAR0 : req_day_number;

   // Stages 2 to 4: cycle count and day within the cycle.
   jdcd_divmod u_divmod (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .in_ctl     (ctl_1_ff),
      .in_value   (x_1_ff),
      .out_ctl    (ctl_4),
      .out_cycles (cyc_4),
      .out_rem    (rem_4)
   );

   // Stage 5: split a 400-year cycle into centuries; cycles to years.
   always_comb begin
      r2_4 = 17'(rem_4 - REM_W'(CENT_FIRST));
      if (r2_4 >= 17'(2 * CENT_DAYS)) begin
         k_4 = 2'd3;
         s_4 = GRP_W'(r2_4 - 17'(2 * CENT_DAYS));
      end else if (r2_4 >= 17'(CENT_DAYS)) begin
         k_4 = 2'd2;
         s_4 = GRP_W'(r2_4 - 17'(CENT_DAYS));
      end else begin
         k_4 = 2'd1;
         s_4 = GRP_W'(r2_4);
      end

      if (!ctl_4.greg || rem_4 < REM_W'(CENT_FIRST)) begin
         g_5_in    = GRP_W'(rem_4);
         base_5_in = '0;
         lf_5_in   = 1'b1;
      end else if (s_4 < GRP_W'(QUAD_COMMON)) begin
         g_5_in    = s_4;
         base_5_in = BASE_W'(k_4) * BASE_W'(100);
         lf_5_in   = 1'b0;
      end else begin
         g_5_in    = s_4 - GRP_W'(QUAD_COMMON);
         base_5_in = BASE_W'(k_4) * BASE_W'(100) + BASE_W'(4);
         lf_5_in   = 1'b1;
      end

      if (ctl_4.greg) begin
         cy_5_in = YEAR_W'(cyc_4) * YEAR_W'(400);
      end else begin
         cy_5_in = YEAR_W'(cyc_4) << 2;
      end
   end

   // Stages 6 and 7: 4-year groups within the century.
   assign gprod_5 = 33'(g_5_ff) * 33'(QUAD_RECIP);
   assign q3_6_in = Q3_W'(gprod_5 >> QUAD_SHIFT);
   assign vraw_6  = g_6_ff - GRP_W'(q3_6_ff) * GRP_W'(JUL_CYCLE);

   always_comb begin
      if (vraw_6 >= GRP_W'(JUL_CYCLE)) begin
         v_7_in  = VAL_W'(vraw_6 - GRP_W'(JUL_CYCLE));
         q3_7_in = q3_6_ff + Q3_W'(1);
      end else begin
         v_7_in  = VAL_W'(vraw_6);
         q3_7_in = q3_6_ff;
      end
   end

   // Stage 8: year within the group, day of year and year sum.
   assign lfx_7 = VAL_W'(lf_7_ff);

   always_comb begin
      if (v_7_ff >= VAL_W'(3 * YEAR_DAYS) + lfx_7) begin
         yi_7     = 2'd3;
         doy_8_in = DOY_W'(v_7_ff - VAL_W'(3 * YEAR_DAYS) - lfx_7);
      end else if (v_7_ff >= VAL_W'(2 * YEAR_DAYS) + lfx_7) begin
         yi_7     = 2'd2;
         doy_8_in = DOY_W'(v_7_ff - VAL_W'(2 * YEAR_DAYS) - lfx_7);
      end else if (v_7_ff >= VAL_W'(YEAR_DAYS) + lfx_7) begin
         yi_7     = 2'd1;
         doy_8_in = DOY_W'(v_7_ff - VAL_W'(YEAR_DAYS) - lfx_7);
      end else begin
         yi_7     = 2'd0;
         doy_8_in = DOY_W'(v_7_ff);
      end
      leap_8_in = lf_7_ff && (yi_7 == 2'd0);
      ysum_8_in = cy_7_ff + YEAR_W'(base_7_ff) + (YEAR_W'(q3_7_ff) << 2) + YEAR_W'(yi_7);
   end

   // Stage 9: month, day and era.
   always_comb begin
      mon_8 = 4'd1;
      for (int i = 1; i < 12; i++) begin
         if (doy_8_ff >= month_start(4'(i), leap_8_ff)) begin
            mon_8 = 4'(i + 1);
         end
      end
      day_9_in = 5'(doy_8_ff - month_start(mon_8 - 4'd1, leap_8_ff) + DOY_W'(1));

      if (ctl_8_ff.greg) begin
         year_9_in = ysum_8_ff;
         bc_9_in   = 1'b0;
      end else if (ysum_8_ff < YEAR_W'(BC_FIRST)) begin
         year_9_in = YEAR_W'(BC_FIRST) - ysum_8_ff;
         bc_9_in   = 1'b1;
      end else begin
         year_9_in = ysum_8_ff - YEAR_W'(AD_OFFSET);
         bc_9_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_1_ff     <= '0;
         ctl_5_ff     <= '0;
         ctl_6_ff     <= '0;
         ctl_7_ff     <= '0;
         ctl_8_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         ctl_1_ff     <= ctl_1_in;
         ctl_5_ff     <= ctl_4;
         ctl_6_ff     <= ctl_5_ff;
         ctl_7_ff     <= ctl_6_ff;
         ctl_8_ff     <= ctl_7_ff;
         rsp_valid_ff <= ctl_8_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_1_ff    <= x_1_in;
         g_5_ff    <= g_5_in;
         base_5_ff <= base_5_in;
         lf_5_ff   <= lf_5_in;
         cy_5_ff   <= cy_5_in;
         g_6_ff    <= g_5_ff;
         base_6_ff <= base_5_ff;
         lf_6_ff   <= lf_5_ff;
         cy_6_ff   <= cy_5_ff;
         q3_6_ff   <= q3_6_in;
         v_7_ff    <= v_7_in;
         q3_7_ff   <= q3_7_in;
         base_7_ff <= base_6_ff;
         lf_7_ff   <= lf_6_ff;
         cy_7_ff   <= cy_6_ff;
         doy_8_ff  <= doy_8_in;
         leap_8_ff <= leap_8_in;
         ysum_8_ff <= ysum_8_in;
         day_9_ff  <= day_9_in;
         mon_9_ff  <= mon_8;
         year_9_ff <= year_9_in;
         bc_9_ff   <= bc_9_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_day_of_month  = day_9_ff;
   assign rsp_month_number  = mon_9_ff;
   assign rsp_year_number   = year_9_ff;
   assign rsp_before_christ = bc_9_ff;

endmodule

>>> hw/rtl/jdcd_checker.sv
// ----------------------------------------------------------------------------
// Julian day to calendar date: port checker
// Watches the ports of the unit and checks result holding, stall behavior
// and the ranges of the date fields.
// ----------------------------------------------------------------------------
module jdcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_day_of_month,
   input logic [3:0]  rsp_month_number,
   input logic [23:0] rsp_year_number,
   input logic        rsp_before_christ
);

   // A result that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_day_of_month)
         && $stable(rsp_month_number) && $stable(rsp_year_number)
         && $stable(rsp_before_christ))
      else $error("result transaction changed while stalled");

   // A waiting result stops new transactions from entering.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the result is stalled");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_number >= 4'd1 && rsp_month_number <= 4'd12)
      else $error("month out of range");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day_of_month >= 5'd1
         && (rsp_month_number != 4'd2 || rsp_day_of_month <= 5'd29))
      else $error("day out of range");

   a_bc_year: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_before_christ |-> rsp_year_number >= 24'd1
         && rsp_year_number <= 24'd4713)
      else $error("BC year out of range");

endmodule

bind julian_day_to_calendar_date_unit jdcd_checker u_jdcd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_day_of_month  (rsp_day_of_month),
   .rsp_month_number  (rsp_month_number),
   .rsp_year_number   (rsp_year_number),
   .rsp_before_christ (rsp_before_christ)
);
